[rtl/session_group_membership_table_assert.svh]
// Assertion macros shared by the checker of the session and group table.
// Depends on a clk and an rst_n in the scope where a macro is used.
`ifndef SESSION_GROUP_MEMBERSHIP_TABLE_ASSERT_SVH
`define SESSION_GROUP_MEMBERSHIP_TABLE_ASSERT_SVH

// Same-cycle implication, skipped while reset is asserted.
`define SGMT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgmt check failed");

// Next-cycle implication, skipped while reset is asserted.
`define SGMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgmt check failed");

`endif

[rtl/sgmt_pkg.sv]
// Shared codes and types for the session and group membership table.
// No dependencies.
package sgmt_pkg;

    localparam int IDX_W = 8;
    localparam int ID_W  = 32;

    localparam logic [3:0] ACT_NEW_SESSION  = 4'd0;
    localparam logic [3:0] ACT_DROP_SESSION = 4'd1;
    localparam logic [3:0] ACT_NEW_GROUP    = 4'd2;
    localparam logic [3:0] ACT_DROP_GROUP   = 4'd3;
    localparam logic [3:0] ACT_ADD_MEMBER   = 4'd4;
    localparam logic [3:0] ACT_DEL_MEMBER   = 4'd5;
    localparam logic [3:0] ACT_ASK_SESSION  = 4'd6;
    localparam logic [3:0] ACT_ASK_GROUP    = 4'd7;
    localparam logic [3:0] ACT_ASK_MEMBER   = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_EXISTS   = 3'd2;
    localparam logic [2:0] ST_NOSLOT   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
    } tok_t;

    typedef struct packed {
        logic            we;
        logic            valid;
        logic [ID_W-1:0] key;
    } cell_wr_t;

    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] key;
    } kill_t;

endpackage

[rtl/sgmt_cell.sv]
// One table slot: valid, key and an auxiliary word, plus one stage of the search chain.
// Depends on sgmt_pkg.
module sgmt_cell
    import sgmt_pkg::*;
#(
    parameter int AUX_W    = 32,
    parameter int CELL_IDX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [ID_W-1:0]  probe_key,
    input  cell_wr_t         wr,
    input  logic [AUX_W-1:0] wr_aux,
    input  kill_t            kill,
    input  tok_t             tok_in,
    input  logic [AUX_W-1:0] aux_in,
    output tok_t             tok_out,
    output logic [AUX_W-1:0] aux_out
);

    logic             valid_reg;
    logic [ID_W-1:0]  key_reg;
    logic [AUX_W-1:0] aux_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [AUX_W-1:0] aux_tok_reg;
    logic [AUX_W-1:0] aux_tok_next;
    logic             match;

    assign match = valid_reg && (key_reg == probe_key);

    always_comb
    begin
        tok_next.hit      = tok_in.hit | match;
        tok_next.hit_idx  = tok_in.hit ? tok_in.hit_idx : IDX_W'(CELL_IDX);
        tok_next.free     = tok_in.free | ~valid_reg;
        tok_next.free_idx = tok_in.free ? tok_in.free_idx : IDX_W'(CELL_IDX);
        aux_tok_next      = tok_in.hit ? aux_in : aux_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr.we)
            begin
                valid_reg <= wr.valid;
            end
            else if (kill.en && (aux_reg[AUX_W-1 -: ID_W] == kill.key))
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        aux_tok_reg <= aux_tok_next;
        if (wr.we)
        begin
            key_reg <= wr.key;
            aux_reg <= wr_aux;
        end
    end

    assign tok_out = tok_reg;
    assign aux_out = aux_tok_reg;

endmodule

[rtl/session_group_membership_table.sv]
// Session and process group table with ordered member lists.
// Depends on sgmt_pkg and sgmt_cell.
//
//  channel   handshake          payload
//  command   start / busy       action, group_id, sess_id, process_id
//  result    done (one cycle)   status, found, owner_session, leader_id
//
// Every command first runs a search through both cell chains. Member commands then
// scan the member memory, one entry a cycle, and a removal shifts the later members
// down, one entry a cycle. Reset empties both tables at once. Results cannot be
// stalled; busy holds off the next command until done.
module session_group_membership_table
    import sgmt_pkg::*;
#(
    parameter int SESSION_SLOTS     = 16,
    parameter int GROUP_SLOTS       = 32,
    parameter int MEMBERS_PER_GROUP = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  action,
    input  logic [31:0] group_id,
    input  logic [31:0] sess_id,
    input  logic [31:0] process_id,
    output logic        done,
    output logic [2:0]  status,
    output logic        found,
    output logic [31:0] owner_session,
    output logic [31:0] leader_id
);

    localparam int SIW   = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
    localparam int GIW   = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int SZW   = $clog2(MEMBERS_PER_GROUP + 1);
    localparam int GAW   = ID_W + SZW;
    localparam int MD    = GROUP_SLOTS * MEMBERS_PER_GROUP;
    localparam int AW    = (MD > 1) ? $clog2(MD) : 1;
    localparam int SCANL = (SESSION_SLOTS > GROUP_SLOTS) ? SESSION_SLOTS : GROUP_SLOTS;
    localparam int CW    = $clog2(SCANL + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MSCAN, S_SHIFT} state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [3:0]       action_reg;
    logic [ID_W-1:0]  gid_reg, sid_reg, pid_reg;
    logic [GIW-1:0]   gidx_reg, gidx_next;
    logic [ID_W-1:0]  gowner_reg, gowner_next;
    logic [SZW-1:0]   gsize_reg, gsize_next;
    logic [SZW-1:0]   ridx_reg, ridx_next;
    logic [SZW-1:0]   pidx_reg, pidx_next;
    logic             pend_reg, pend_next;
    logic             done_reg, done_next;
    logic [2:0]       status_reg, status_next;
    logic             found_reg, found_next;
    logic [ID_W-1:0]  owner_reg, owner_next;
    logic [ID_W-1:0]  leader_reg, leader_next;

    // chains
    tok_t             s_tok [0:SESSION_SLOTS];
    logic [ID_W-1:0]  s_aux [0:SESSION_SLOTS];
    tok_t             g_tok [0:GROUP_SLOTS];
    logic [GAW-1:0]   g_aux [0:GROUP_SLOTS];
    cell_wr_t         s_wr  [0:SESSION_SLOTS-1];
    cell_wr_t         g_wr  [0:GROUP_SLOTS-1];
    logic             s_wr_en, g_wr_en, s_wr_valid, g_wr_valid;
    logic [SIW-1:0]   s_wr_idx;
    logic [GIW-1:0]   g_wr_idx;
    logic [GAW-1:0]   g_wr_aux;
    kill_t            kill;
    tok_t             s_end, g_end;
    logic [GAW-1:0]   g_end_aux;

    // member memory
    logic [ID_W-1:0]  mem [0:MD-1];
    logic [ID_W-1:0]  mem_q;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [ID_W-1:0]  mem_wdata;
    logic             accept;

    function automatic logic [AW-1:0] maddr(input logic [GIW-1:0] g, input logic [SZW-1:0] o);
        maddr = AW'(int'(g) * MEMBERS_PER_GROUP + int'(o));
    endfunction

    assign s_tok[0] = '0;
    assign s_aux[0] = '0;
    assign g_tok[0] = '0;
    assign g_aux[0] = '0;
    assign s_end     = s_tok[SESSION_SLOTS];
    assign g_end     = g_tok[GROUP_SLOTS];
    assign g_end_aux = g_aux[GROUP_SLOTS];

    genvar i;
    generate
        for (i = 0; i < SESSION_SLOTS; i++)
        begin : g_sess
            assign s_wr[i] = '{we: s_wr_en && (s_wr_idx == SIW'(i)), valid: s_wr_valid,
                               key: sid_reg};
            sgmt_cell #(.AUX_W(ID_W), .CELL_IDX(i)) u_cell (
                .clk(clk), .rst_n(rst_n), .probe_key(sid_reg), .wr(s_wr[i]),
                .wr_aux(sid_reg), .kill(kill), .tok_in(s_tok[i]), .aux_in(s_aux[i]),
                .tok_out(s_tok[i+1]), .aux_out(s_aux[i+1])
            );
        end
        for (i = 0; i < GROUP_SLOTS; i++)
        begin : g_grp
            assign g_wr[i] = '{we: g_wr_en && (g_wr_idx == GIW'(i)), valid: g_wr_valid,
                               key: gid_reg};
            sgmt_cell #(.AUX_W(GAW), .CELL_IDX(i)) u_cell (
                .clk(clk), .rst_n(rst_n), .probe_key(gid_reg), .wr(g_wr[i]),
                .wr_aux(g_wr_aux), .kill(kill), .tok_in(g_tok[i]), .aux_in(g_aux[i]),
                .tok_out(g_tok[i+1]), .aux_out(g_aux[i+1])
            );
        end
    endgenerate

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        gidx_next   = gidx_reg;
        gowner_next = gowner_reg;
        gsize_next  = gsize_reg;
        ridx_next   = ridx_reg;
        pidx_next   = pidx_reg;
        pend_next   = pend_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        owner_next  = owner_reg;
        leader_next = leader_reg;
        s_wr_en     = 1'b0;
        s_wr_idx    = s_end.free_idx[SIW-1:0];
        s_wr_valid  = 1'b1;
        g_wr_en     = 1'b0;
        g_wr_idx    = gidx_reg;
        g_wr_valid  = 1'b1;
        g_wr_aux    = {gowner_reg, gsize_reg};
        kill        = '{en: 1'b0, key: sid_reg};
        mem_we      = 1'b0;
        mem_waddr   = maddr(gidx_reg, pidx_reg);
        mem_wdata   = mem_q;
        mem_raddr   = maddr(gidx_reg, ridx_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg != CW'(SCANL))
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    gidx_next   = g_end.hit_idx[GIW-1:0];
                    gowner_next = g_end_aux[GAW-1 -: ID_W];
                    gsize_next  = g_end_aux[SZW-1:0];
                    ridx_next   = '0;
                    pend_next   = 1'b0;
                    // finish by default; member actions override below
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                    owner_next  = '0;
                    leader_next = '0;
                    unique case (action_reg)
                        ACT_NEW_SESSION:
                        begin
                            if (sid_reg == '0)
                                status_next = ST_INVALID;
                            else if (s_end.hit)
                                status_next = ST_EXISTS;
                            else if (!s_end.free)
                                status_next = ST_NOSLOT;
                            else
                                s_wr_en = 1'b1;
                        end
                        ACT_DROP_SESSION:
                        begin
                            if (!s_end.hit)
                                status_next = ST_NOTFOUND;
                            else
                                kill.en = 1'b1;
                        end
                        ACT_NEW_GROUP:
                        begin
                            g_wr_idx = g_end.free_idx[GIW-1:0];
                            g_wr_aux = {sid_reg, SZW'(0)};
                            if (gid_reg == '0)
                                status_next = ST_INVALID;
                            else if (!s_end.hit)
                                status_next = ST_NOTFOUND;
                            else if (g_end.hit)
                                status_next = ST_EXISTS;
                            else if (!g_end.free)
                                status_next = ST_NOSLOT;
                            else
                                g_wr_en = 1'b1;
                        end
                        ACT_DROP_GROUP:
                        begin
                            g_wr_idx   = g_end.hit_idx[GIW-1:0];
                            g_wr_aux   = g_end_aux;
                            g_wr_valid = 1'b0;
                            if (!g_end.hit)
                                status_next = ST_NOTFOUND;
                            else
                                g_wr_en = 1'b1;
                        end
                        ACT_ADD_MEMBER:
                        begin
                            if (gid_reg == '0 || pid_reg == '0)
                                status_next = ST_INVALID;
                            else if (!g_end.hit)
                                status_next = ST_NOTFOUND;
                            else
                            begin
                                state_next = S_MSCAN;
                                done_next  = 1'b0;
                            end
                        end
                        ACT_DEL_MEMBER:
                        begin
                            if (!g_end.hit)
                                status_next = ST_NOTFOUND;
                            else
                            begin
                                state_next = S_MSCAN;
                                done_next  = 1'b0;
                            end
                        end
                        ACT_ASK_SESSION:
                        begin
                            found_next  = s_end.hit;
                            leader_next = s_end.hit ? s_aux[SESSION_SLOTS] : '0;
                        end
                        ACT_ASK_GROUP:
                        begin
                            found_next  = g_end.hit;
                            owner_next  = g_end.hit ? g_end_aux[GAW-1 -: ID_W] : '0;
                            leader_next = g_end.hit ? gid_reg : '0;
                        end
                        ACT_ASK_MEMBER:
                        begin
                            if (g_end.hit)
                            begin
                                state_next = S_MSCAN;
                                done_next  = 1'b0;
                            end
                        end
                        default:
                        begin
                            status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_MSCAN:
            begin
                if (pend_reg && (mem_q == pid_reg))
                begin
                    pend_next = 1'b0;
                    if (action_reg == ACT_DEL_MEMBER)
                    begin
                        state_next = S_SHIFT;
                        ridx_next  = pidx_reg + 1'b1;
                    end
                    else
                    begin
                        state_next  = S_IDLE;
                        done_next   = 1'b1;
                        status_next = ST_OK;
                        found_next  = (action_reg == ACT_ASK_MEMBER);
                    end
                end
                else if (ridx_reg < gsize_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ridx_reg;
                    ridx_next = ridx_reg + 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    // not a member
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    found_next  = 1'b0;
                    status_next = ST_OK;
                    if (action_reg == ACT_DEL_MEMBER)
                    begin
                        status_next = ST_NOTFOUND;
                    end
                    else if (action_reg == ACT_ADD_MEMBER)
                    begin
                        if (gsize_reg >= SZW'(MEMBERS_PER_GROUP))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = maddr(gidx_reg, gsize_reg);
                            mem_wdata = pid_reg;
                            g_wr_en   = 1'b1;
                            g_wr_aux  = {gowner_reg, gsize_reg + 1'b1};
                        end
                    end
                end
            end
            S_SHIFT:
            begin
                // pidx_reg holds the destination of the pending read
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (ridx_reg < gsize_reg)
                begin
                    pend_next = 1'b1;
                    pidx_next = ridx_reg - 1'b1;
                    ridx_next = ridx_reg + 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = maddr(gidx_reg, gsize_reg - 1'b1);
                    mem_wdata   = '0;
                    g_wr_en     = 1'b1;
                    g_wr_aux    = {gowner_reg, gsize_reg - 1'b1};
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    found_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            pend_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= 1'b0;
            owner_reg  <= '0;
            leader_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pend_reg   <= pend_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            owner_reg  <= owner_next;
            leader_reg <= leader_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            gid_reg    <= group_id;
            sid_reg    <= sess_id;
            pid_reg    <= process_id;
        end
        gidx_reg   <= gidx_next;
        gowner_reg <= gowner_next;
        gsize_reg  <= gsize_next;
        ridx_reg   <= ridx_next;
        pidx_reg   <= pidx_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign owner_session = owner_reg;
    assign leader_id     = leader_reg;

endmodule

[rtl/sgmt_checker.sv]
// Port-level checks for the session and group table, bound to the top level.
// Depends on sgmt_pkg and session_group_membership_table_assert.svh.
`include "session_group_membership_table_assert.svh"

module sgmt_checker
    import sgmt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [2:0]  status,
    input logic        found,
    input logic [31:0] owner_session,
    input logic [31:0] leader_id
);

    `SGMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `SGMT_ASSERT_NOW(a_fall_done, $fell(busy), done)
    `SGMT_ASSERT_NOW(a_found_ok, done && found, status == ST_OK)
    `SGMT_ASSERT_NOW(a_fail_zero, done && (status != ST_OK),
        !found && (owner_session == '0) && (leader_id == '0))

endmodule

bind session_group_membership_table sgmt_checker u_sgmt_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .found(found), .owner_session(owner_session), .leader_id(leader_id)
);

[sim/tb.sv]
// Self-checking bench for session_group_membership_table: table commands in, one result out.
// Depends on sgmt_pkg and the top level of the block; compares against a local table model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgmt_pkg::*;

    localparam int NS = 16;
    localparam int NG = 32;
    localparam int NM = 16;

    typedef struct packed {
        logic [3:0]  action;
        logic [31:0] gid;
        logic [31:0] sid;
        logic [31:0] pid;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [31:0] owner;
        logic [31:0] leader;
    } reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [3:0]  action;
    logic [31:0] group_id;
    logic [31:0] sess_id;
    logic [31:0] process_id;
    logic        done;
    logic [2:0]  status;
    logic        found;
    logic [31:0] owner_session;
    logic [31:0] leader_id;

    session_group_membership_table uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .group_id(group_id), .sess_id(sess_id),
        .process_id(process_id), .done(done), .status(status), .found(found),
        .owner_session(owner_session), .leader_id(leader_id)
    );

    // local copy of the tables
    bit          s_valid [NS];
    logic [31:0] s_key   [NS];
    bit          g_valid [NG];
    logic [31:0] g_key   [NG];
    logic [31:0] g_owner [NG];
    int          g_size  [NG];
    logic [31:0] members [NG][NM];

    cmd_t   pending_cmds[$];
    reply_t expected_replies[$];
    int     errors = 0;
    int     replies_seen = 0;
    int     gap = 0;
    bit     stim_done = 0;

    function automatic int lookup_session(logic [31:0] id);
        for (int i = 0; i < NS; i++)
            if (s_valid[i] && s_key[i] == id) return i;
        return -1;
    endfunction

    function automatic int find_group(logic [31:0] id);
        for (int i = 0; i < NG; i++)
            if (g_valid[i] && g_key[i] == id) return i;
        return -1;
    endfunction

    function automatic int find_member(int g, logic [31:0] p);
        for (int i = 0; i < g_size[g]; i++)
            if (members[g][i] == p) return i;
        return -1;
    endfunction

    function automatic reply_t apply_command(cmd_t c);
        reply_t r;
        int s;
        int g;
        int m;
        r = '0;
        r.status = ST_OK;
        case (c.action)
            ACT_NEW_SESSION:
                if (c.sid == 0) r.status = ST_INVALID;
                else if (lookup_session(c.sid) >= 0) r.status = ST_EXISTS;
                else begin
                    r.status = ST_NOSLOT;
                    for (int i = 0; i < NS; i++)
                        if (!s_valid[i])
                        begin
                            s_valid[i] = 1;
                            s_key[i] = c.sid;
                            r.status = ST_OK;
                            break;
                        end
                end
            ACT_DROP_SESSION:
            begin
                s = lookup_session(c.sid);
                if (s < 0) r.status = ST_NOTFOUND;
                else begin
                    for (int i = 0; i < NG; i++)
                        if (g_valid[i] && g_owner[i] == c.sid) g_valid[i] = 0;
                    s_valid[s] = 0;
                end
            end
            ACT_NEW_GROUP:
                if (c.gid == 0) r.status = ST_INVALID;
                else if (lookup_session(c.sid) < 0) r.status = ST_NOTFOUND;
                else if (find_group(c.gid) >= 0) r.status = ST_EXISTS;
                else begin
                    r.status = ST_NOSLOT;
                    for (int i = 0; i < NG; i++)
                        if (!g_valid[i])
                        begin
                            g_valid[i] = 1;
                            g_key[i] = c.gid;
                            g_owner[i] = c.sid;
                            g_size[i] = 0;
                            for (int k = 0; k < NM; k++) members[i][k] = 0;
                            r.status = ST_OK;
                            break;
                        end
                end
            ACT_DROP_GROUP:
            begin
                g = find_group(c.gid);
                if (g < 0) r.status = ST_NOTFOUND;
                else g_valid[g] = 0;
            end
            ACT_ADD_MEMBER:
            begin
                g = find_group(c.gid);
                if (c.gid == 0 || c.pid == 0) r.status = ST_INVALID;
                else if (g < 0) r.status = ST_NOTFOUND;
                else if (find_member(g, c.pid) >= 0) r.status = ST_OK;
                else if (g_size[g] >= NM) r.status = ST_FULL;
                else begin
                    members[g][g_size[g]] = c.pid;
                    g_size[g]++;
                end
            end
            ACT_DEL_MEMBER:
            begin
                g = find_group(c.gid);
                m = (g >= 0) ? find_member(g, c.pid) : -1;
                if (m < 0) r.status = ST_NOTFOUND;
                else begin
                    for (int i = m; i + 1 < g_size[g]; i++) members[g][i] = members[g][i+1];
                    members[g][g_size[g]-1] = 0;
                    g_size[g]--;
                end
            end
            ACT_ASK_SESSION:
                if (lookup_session(c.sid) >= 0)
                begin
                    r.found = 1;
                    r.leader = c.sid;
                end
            ACT_ASK_GROUP:
            begin
                g = find_group(c.gid);
                if (g >= 0)
                begin
                    r.found = 1;
                    r.owner = g_owner[g];
                    r.leader = c.gid;
                end
            end
            ACT_ASK_MEMBER:
            begin
                g = find_group(c.gid);
                if (g >= 0 && find_member(g, c.pid) >= 0) r.found = 1;
            end
            default: r.status = ST_INVALID;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] pick_id(int span);
        case ($urandom_range(0, 19))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, span);
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    task automatic push(logic [3:0] a, logic [31:0] g, logic [31:0] s, logic [31:0] p);
        cmd_t c;
        c.action = a;
        c.gid = g;
        c.sid = s;
        c.pid = p;
        pending_cmds.push_back(c);
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout at %0t", $time);
        $display("Regression FAIL");
        $finish;
    end

    // driver: prediction is made at the transfer edge so it sees state in command order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 0;
            action <= '0;
            group_id <= '0;
            sess_id <= '0;
            process_id <= '0;
            gap <= 0;
        end
        else if (start && !busy)
        begin
            expected_replies.push_back(apply_command({action, group_id, sess_id, process_id}));
            start <= 0;
            gap <= pick_gap();
        end
        else if (!start)
        begin
            if (gap > 0) gap <= gap - 1;
            else if (pending_cmds.size() > 0)
            begin
                {action, group_id, sess_id, process_id} <= pending_cmds.pop_front();
                start <= 1;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            reply_t w;
            replies_seen++;
            if (expected_replies.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d", $time, status);
                errors++;
            end
            else begin
                w = expected_replies.pop_front();
                if (w.status !== status || w.found !== found ||
                    w.owner !== owner_session || w.leader !== leader_id)
                begin
                    $display("%0t: mismatch expected st=%0d f=%0d own=%h ldr=%h", $time,
                             w.status, w.found, w.owner, w.leader);
                    $display("%0t:          actual   st=%0d f=%0d own=%h ldr=%h", $time,
                             status, found, owner_session, leader_id);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cmd_t c;
        int kind;
        logic [31:0] g;
        rst_n = 0;
        for (int i = 0; i < NS; i++) begin s_valid[i] = 0; s_key[i] = 0; end
        for (int i = 0; i < NG; i++)
        begin
            g_valid[i] = 0; g_key[i] = 0; g_owner[i] = 0; g_size[i] = 0;
            for (int k = 0; k < NM; k++) members[i][k] = 0;
        end
        // directed: invalid ids, unknown actions, extremes, full lists, drop cascade
        push(ACT_NEW_SESSION, 0, 0, 0);
        push(ACT_NEW_SESSION, 0, 32'hFFFF_FFFF, 0);
        push(ACT_NEW_SESSION, 0, 32'hFFFF_FFFF, 0);
        push(ACT_NEW_GROUP, 0, 32'hFFFF_FFFF, 0);
        push(ACT_NEW_GROUP, 5, 7, 0);
        push(ACT_NEW_GROUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        push(ACT_NEW_GROUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        push(ACT_ADD_MEMBER, 32'hFFFF_FFFF, 0, 0);
        push(ACT_ADD_MEMBER, 0, 0, 9);
        push(ACT_ADD_MEMBER, 3, 0, 9);
        push(ACT_ADD_MEMBER, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        push(ACT_ADD_MEMBER, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        push(ACT_ASK_MEMBER, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        push(ACT_ASK_GROUP, 32'hFFFF_FFFF, 0, 0);
        push(ACT_ASK_SESSION, 0, 32'hFFFF_FFFF, 0);
        push(ACT_DEL_MEMBER, 32'hFFFF_FFFF, 0, 4);
        push(ACT_DEL_MEMBER, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        push(ACT_DROP_GROUP, 8, 0, 0);
        push(ACT_DROP_SESSION, 0, 32'hFFFF_FFFF, 0);
        push(ACT_ASK_GROUP, 32'hFFFF_FFFF, 0, 0);
        push(ACT_DROP_SESSION, 0, 32'hFFFF_FFFF, 0);
        push(4'd9, 1, 1, 1);
        push(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // fill a group past its limit, then shift from the middle
        push(ACT_NEW_SESSION, 0, 1, 0);
        push(ACT_NEW_GROUP, 2, 1, 0);
        for (int i = 1; i <= NM + 1; i++) push(ACT_ADD_MEMBER, 2, 0, i);
        push(ACT_DEL_MEMBER, 2, 0, 5);
        push(ACT_ASK_MEMBER, 2, 0, 16);
        // fill both tables
        for (int i = 2; i <= NS + 1; i++) push(ACT_NEW_SESSION, 0, i, 0);
        for (int i = 3; i <= NG + 3; i++) push(ACT_NEW_GROUP, i, 1, 0);
        push(ACT_DROP_SESSION, 0, 1, 0);
        // random: small id pools so commands hit live entries
        for (int n = 0; n < 1400; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 6) c.action = ACT_NEW_SESSION;
            else if (kind < 9) c.action = ACT_DROP_SESSION;
            else if (kind < 20) c.action = ACT_NEW_GROUP;
            else if (kind < 24) c.action = ACT_DROP_GROUP;
            else if (kind < 52) c.action = ACT_ADD_MEMBER;
            else if (kind < 66) c.action = ACT_DEL_MEMBER;
            else if (kind < 72) c.action = ACT_ASK_SESSION;
            else if (kind < 80) c.action = ACT_ASK_GROUP;
            else if (kind < 97) c.action = ACT_ASK_MEMBER;
            else c.action = $urandom_range(0, 15);
            g = pick_id(40);
            c.gid = g;
            c.sid = pick_id(20);
            c.pid = pick_id(24);
            pending_cmds.push_back(c);
        end
        repeat (8) @(posedge clk);
        rst_n <= 1;
        wait (pending_cmds.size() == 0);
        @(posedge clk);
        while (start || expected_replies.size() > 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Ran %0d table commands, %0d results checked, %0d errors.",
                 replies_seen, replies_seen, errors);
        if (errors == 0 && expected_replies.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/sgmt_pkg.sv
rtl/sgmt_cell.sv
rtl/session_group_membership_table.sv
rtl/sgmt_checker.sv
sim/tb.sv
